// File: rtl/core/ssda_pkg.sv
package ssda_pkg;

    localparam int COUNT_W = 10;
    localparam int VALUE_W = 10;
    localparam int LIMIT_W = 16;
    localparam int SEG_W   = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int WARMUP_ITEMS_DEFAULT = 16;

    localparam logic [COUNT_W-1:0] SCALE_OFFSET = 10'd215;
    localparam logic [10:0]        SCALE_GAIN   = 11'd1173;
    localparam int                 SCALE_SHIFT  = 10;

    localparam logic [SEG_W-1:0] DOT_BIT = 8'h80;

    typedef enum logic [2:0] {
        REG_TEMP_HIGH = 3'd0,
        REG_TEMP_LOW  = 3'd1,
        REG_HUM_HIGH  = 3'd2,
        REG_HUM_LOW   = 3'd3,
        REG_RAW_MODE  = 3'd4
    } reg_idx_t;

    typedef logic [SEG_W-1:0] seg_code_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] temp_high;
        logic [LIMIT_W-1:0] temp_low;
        logic [LIMIT_W-1:0] hum_high;
        logic [LIMIT_W-1:0] hum_low;
        logic               raw_mode;
    } cfg_t;

    // Segment bit 0 is segment a through bit 6 segment g.
    function automatic seg_code_t seg_encode(input logic [3:0] digit);
        seg_code_t code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Shift-and-add-three conversion; four digits cover values up to 1023.
    function automatic logic [15:0] bin_to_bcd(input logic [VALUE_W-1:0] bin);
        logic [15:0] bcd;
        bcd = '0;
        for (int i = VALUE_W - 1; i >= 0; i--) begin
            for (int d = 0; d < 4; d++) begin
                if (bcd[4*d +: 4] >= 4'd5) begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            bcd = {bcd[14:0], bin[i]};
        end
        return bcd;
    endfunction

endpackage

// File: rtl/core/ssda_scale.sv
module ssda_scale
    import ssda_pkg::*;
(
    input  logic [COUNT_W-1:0] counts,
    input  logic               raw_mode,
    output logic [VALUE_W-1:0] value
);

    logic [COUNT_W-1:0]    offset_counts;
    logic [COUNT_W+10:0]   product;

    assign offset_counts = counts - SCALE_OFFSET;
    assign product       = (COUNT_W + 11)'(offset_counts) * (COUNT_W + 11)'(SCALE_GAIN);

    always_comb
    begin
        if (raw_mode) begin
            value = counts;
        end else if (counts < SCALE_OFFSET) begin
            value = '0;
        end else begin
            // The scaled value never exceeds 925, so ten bits hold it.
            value = product[SCALE_SHIFT +: VALUE_W];
        end
    end

endmodule

// File: rtl/core/ssda_seg.sv
module ssda_seg
    import ssda_pkg::*;
(
    input  logic [VALUE_W-1:0] value,
    output seg_code_t          seg_units,
    output seg_code_t          seg_tens,
    output seg_code_t          seg_hundreds
);

    logic [15:0] bcd;

    // Any thousands digit in raw mode is simply not shown.
    assign bcd          = bin_to_bcd(value);
    assign seg_units    = seg_encode(bcd[3:0]);
    assign seg_tens     = seg_encode(bcd[7:4]) | DOT_BIT;
    assign seg_hundreds = seg_encode(bcd[11:8]);

endmodule

// File: rtl/core/sensor_scale_display_alarm_core.sv
// An accepted item passes through the input register and then the result
// register, from which its result is taken.
// Throughput: one item per cycle; items stream back to back through the input
// register and the result register, which stall together only while a
// result waits on out_stall.
// Reset (rst_n, asynchronous, active low) clears all limits, raw mode, the
// warm-up count, both lamps and the valid flags.
module sensor_scale_display_alarm_core
    import ssda_pkg::*;
#(
    parameter int WARMUP_ITEMS = WARMUP_ITEMS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COUNT_W-1:0] hum_counts,
    input  logic [COUNT_W-1:0] temp_counts,
    input  logic               alarm_switch,

    output logic               out_valid,
    input  logic               out_stall,
    output seg_code_t          seg_digit0,
    output seg_code_t          seg_digit1,
    output seg_code_t          seg_digit2,
    output seg_code_t          seg_digit3,
    output seg_code_t          seg_digit4,
    output seg_code_t          seg_digit5,
    output logic               fault_lamp,
    output logic               ok_lamp
);

    localparam int CntW = (WARMUP_ITEMS < 1) ? 1 : $clog2(WARMUP_ITEMS + 1);
    localparam logic [CntW-1:0] WarmupLimit = CntW'(WARMUP_ITEMS);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cfg_write;
    logic [2:0] reg_index;

    logic               s1_valid_reg;
    logic [COUNT_W-1:0] s1_hum_reg;
    logic [COUNT_W-1:0] s1_temp_reg;
    logic               s1_switch_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    seg_code_t          seg_reg [6];
    seg_code_t          seg_next [6];
    logic [CntW-1:0]    warmup_reg;
    logic [CntW-1:0]    warmup_next;
    logic               red_reg;
    logic               red_next;
    logic               green_reg;
    logic               green_next;

    logic               advance;
    logic               item_done;
    logic               warm;
    logic               out_of_range;
    logic [VALUE_W-1:0] hum_value;
    logic [VALUE_W-1:0] temp_value;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (reg_index)
                REG_TEMP_HIGH: cfg_next.temp_high = pwdata[LIMIT_W-1:0];
                REG_TEMP_LOW:  cfg_next.temp_low  = pwdata[LIMIT_W-1:0];
                REG_HUM_HIGH:  cfg_next.hum_high  = pwdata[LIMIT_W-1:0];
                REG_HUM_LOW:   cfg_next.hum_low   = pwdata[LIMIT_W-1:0];
                REG_RAW_MODE:  cfg_next.raw_mode  = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_TEMP_HIGH: prdata = DATA_W'(cfg_reg.temp_high);
            REG_TEMP_LOW:  prdata = DATA_W'(cfg_reg.temp_low);
            REG_HUM_HIGH:  prdata = DATA_W'(cfg_reg.hum_high);
            REG_HUM_LOW:   prdata = DATA_W'(cfg_reg.hum_low);
            REG_RAW_MODE:  prdata = DATA_W'(cfg_reg.raw_mode);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Both stages move together whenever the result register is empty or its result is taken.
    assign advance   = !(out_valid_reg && out_stall);
    assign in_stall  = !advance;
    assign item_done = advance && s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_hum_reg    <= hum_counts;
            s1_temp_reg   <= temp_counts;
            s1_switch_reg <= alarm_switch;
        end
    end

    ssda_scale u_scale_hum (
        .counts   (s1_hum_reg),
        .raw_mode (cfg_reg.raw_mode),
        .value    (hum_value)
    );

    ssda_scale u_scale_temp (
        .counts   (s1_temp_reg),
        .raw_mode (cfg_reg.raw_mode),
        .value    (temp_value)
    );

    ssda_seg u_seg_hum (
        .value        (hum_value),
        .seg_units    (seg_next[0]),
        .seg_tens     (seg_next[1]),
        .seg_hundreds (seg_next[2])
    );

    ssda_seg u_seg_temp (
        .value        (temp_value),
        .seg_units    (seg_next[3]),
        .seg_tens     (seg_next[4]),
        .seg_hundreds (seg_next[5])
    );

    // Crossed limits make every value out of range, which the plain window
    // test already gives.
    assign out_of_range = (LIMIT_W'(temp_value) < cfg_reg.temp_low)  ||
                          (LIMIT_W'(temp_value) > cfg_reg.temp_high) ||
                          (LIMIT_W'(hum_value)  < cfg_reg.hum_low)   ||
                          (LIMIT_W'(hum_value)  > cfg_reg.hum_high);

    assign warm = (warmup_reg >= WarmupLimit);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        warmup_next    = warmup_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        if (advance) begin
            out_valid_next = s1_valid_reg;
        end
        if (item_done) begin
            if (!warm) begin
                warmup_next = warmup_reg + 1'b1;
            end else if (s1_switch_reg) begin
                red_next   = out_of_range;
                green_next = !out_of_range;
            end else begin
                red_next   = 1'b0;
                green_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            warmup_reg    <= '0;
            red_reg       <= 1'b0;
            green_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            warmup_reg    <= warmup_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_done) begin
            for (int i = 0; i < 6; i++) begin
                seg_reg[i] <= seg_next[i];
            end
        end
    end

    // The lamp registers are the lamp state that each result carries.
    assign out_valid  = out_valid_reg;
    assign seg_digit0 = seg_reg[0];
    assign seg_digit1 = seg_reg[1];
    assign seg_digit2 = seg_reg[2];
    assign seg_digit3 = seg_reg[3];
    assign seg_digit4 = seg_reg[4];
    assign seg_digit5 = seg_reg[5];
    assign fault_lamp = red_reg;
    assign ok_lamp    = green_reg;

`ifndef SYNTH
    a_lamps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(red_reg && green_reg))
        else $error("red and green lamps lit together");

    a_warmup_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        warmup_reg <= WarmupLimit)
        else $error("warm-up count ran past its limit");

    a_warmup_holds_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        (item_done && !warm) |=> ($stable(red_reg) && $stable(green_reg)))
        else $error("lamps changed during warm-up");

    a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        item_done |=> out_valid_reg)
        else $error("item in the input register did not reach the result register");
`endif

endmodule
